@@ hw/rtl/tes_pkg.sv @@
// shared widths, types and register codes of the triangle stiffness block
`timescale 1ns / 1ps

package tes_pkg;

  // vertex coordinates and coefficients
  localparam int VW  = 32;
  // edge and b/c components, signed
  localparam int CW  = VW + 1;
  // magnitude of one component
  localparam int MW  = 32;
  // product of two magnitudes
  localparam int PW  = 2 * MW;
  // product of two magnitudes and one coefficient
  localparam int TW  = PW + VW;
  // magnitude of the numerator
  localparam int NW  = TW + 1;
  // signed numerator
  localparam int SW  = TW + 2;
  // twice the absolute doubled area
  localparam int DW  = 2 * CW;
  // quotient bits below the saturation limit
  localparam int QW  = 47;
  // remainder width inside the divider
  localparam int RW  = DW + QW;
  // entry width
  localparam int EW  = 48;
  // row and column index width
  localparam int IW  = 3;
  // last row / column of the matrix
  localparam logic [IW-1:0] LAST_IDX = 3'd5;
  localparam logic [IW-1:0] V_BASE   = 3'd3;

  // configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_NORMAL   = 2'd0;
  localparam cfg_idx_t CFG_COUPLING = 2'd1;
  localparam cfg_idx_t CFG_SHEAR    = 2'd2;

  // per-entry control that travels along the pipeline
  typedef struct packed {
    logic [IW-1:0] row;
    logic [IW-1:0] col;
    logic          deg;
    logic          last;
    logic [DW-1:0] den;
  } ent_tag_t;

endpackage

@@ hw/rtl/tes_div_pipe.sv @@
// pipelined saturating divider: numerator magnitude over twice the doubled area, one bit per stage
`timescale 1ns / 1ps

module tes_div_pipe
  import tes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_vld,
  input  logic [NW-1:0]        in_num,
  input  logic                 in_neg,
  input  ent_tag_t             in_tag,
  output logic                 out_vld,
  output logic [IW-1:0]        out_row,
  output logic [IW-1:0]        out_col,
  output logic signed [EW-1:0] out_val,
  output logic                 out_deg,
  output logic                 out_last
);

  logic           vld_r [0:QW];
  logic [RW-1:0]  rem_r [0:QW];
  logic [QW-1:0]  q_r   [0:QW];
  logic           neg_r [0:QW];
  logic           sat_r [0:QW];
  ent_tag_t       tag_r [0:QW];

  logic                 ovld_r;
  logic [IW-1:0]        orow_r;
  logic [IW-1:0]        ocol_r;
  logic signed [EW-1:0] oval_r;
  logic                 odeg_r;
  logic                 olast_r;

  logic [EW-1:0] mag_nxt;
  logic [EW-1:0] val_nxt;

  // entry stage: saturation check against den shifted past the quotient range
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
    rem_r[0] <= {{(RW-NW){1'b0}}, in_num};
    q_r[0]   <= '0;
    neg_r[0] <= in_neg;
    sat_r[0] <= ({{(RW-NW){1'b0}}, in_num} >= {in_tag.den, {QW{1'b0}}});
    tag_r[0] <= in_tag;
  end

  // one restoring step per stage, quotient msb first
  genvar j;
  for (j = 0; j < QW; j++) begin : g_stage
    logic [RW-1:0] dsh;
    logic          fit;
    assign dsh = {{QW{1'b0}}, tag_r[j].den} << (QW - 1 - j);
    assign fit = (rem_r[j] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_r[j];
      end
      rem_r[j+1] <= fit ? (rem_r[j] - dsh) : rem_r[j];
      q_r[j+1]   <= {q_r[j][QW-2:0], fit};
      neg_r[j+1] <= neg_r[j];
      sat_r[j+1] <= sat_r[j];
      tag_r[j+1] <= tag_r[j];
    end
  end

  // clamp, apply sign, zero degenerate triangles
  always_comb begin
    if (sat_r[QW]) begin
      mag_nxt = neg_r[QW] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    end else begin
      mag_nxt = {1'b0, q_r[QW]};
    end
    if (tag_r[QW].deg) begin
      val_nxt = '0;
    end else begin
      val_nxt = neg_r[QW] ? (~mag_nxt + 1'b1) : mag_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else begin
      ovld_r <= vld_r[QW];
    end
    orow_r  <= tag_r[QW].row;
    ocol_r  <= tag_r[QW].col;
    oval_r  <= val_nxt;
    odeg_r  <= tag_r[QW].deg;
    olast_r <= tag_r[QW].last;
  end

  assign out_vld  = ovld_r;
  assign out_row  = orow_r;
  assign out_col  = ocol_r;
  assign out_val  = oval_r;
  assign out_deg  = odeg_r;
  assign out_last = olast_r;

endmodule

@@ hw/rtl/tri_elastic_stiffness_core.sv @@
// top level of the linear triangle plane elasticity stiffness block
`timescale 1ns / 1ps
// usage:
// - write normal_coeff, coupling_coeff and shear_modulus through the cfg_ channel
//   (cfg_ready is always high, index 3 is ignored) while no item is in flight
// - a triangle item is taken at an edge with start high and busy low
// - each item yields 21 entries, upper triangle of the 6x6 matrix in row-major order,
//   one per cycle, each shown for one cycle with out_valid high; last_entry marks (5,5)
// - the entry sequencer paces the items: the next
//   item's geometry is prepared while the current one is still streaming
// - the path to the first entry: 3 geometry stages, the sequencer, 7 multiply/add stages
//   and a divider with an entry stage, 47 restoring stages and an output register
// - the receiver cannot stall, so entries leave at the rate they are produced
// - synchronous reset clears all valid bits and the three coefficients to zero
module tri_elastic_stiffness_core
  import tes_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [VW-1:0] in_vx0,
  input  logic signed [VW-1:0] in_vy0,
  input  logic signed [VW-1:0] in_vx1,
  input  logic signed [VW-1:0] in_vy1,
  input  logic signed [VW-1:0] in_vx2,
  input  logic signed [VW-1:0] in_vy2,
  output logic                 out_valid,
  output logic [IW-1:0]        out_row_index,
  output logic [IW-1:0]        out_col_index,
  output logic signed [EW-1:0] out_entry_value,
  output logic                 out_degenerate,
  output logic                 out_last_entry,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  cfg_idx_t             cfg_index,
  input  logic [VW-1:0]        cfg_data
);

  // configuration
  logic [VW-1:0] cii_r, cij_r, mu_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cii_r <= '0;
      cij_r <= '0;
      mu_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_NORMAL:   cii_r <= cfg_data;
        CFG_COUPLING: cij_r <= cfg_data;
        CFG_SHEAR:    mu_r  <= cfg_data;
        default: ;
      endcase
    end
  end
  assign cfg_ready = 1'b1;

  // geometry stage 1: vertex latch
  logic                 g1_vld_r;
  logic signed [VW-1:0] x0_r, y0_r, x1_r, y1_r, x2_r, y2_r;
  logic                 accept;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_vld_r <= 1'b0;
    end else begin
      g1_vld_r <= accept;
    end
    if (accept) begin
      x0_r <= in_vx0;
      y0_r <= in_vy0;
      x1_r <= in_vx1;
      y1_r <= in_vy1;
      x2_r <= in_vx2;
      y2_r <= in_vy2;
    end
  end

  // geometry stage 2: edges, b, c and the two cross products
  logic                   g2_vld_r;
  logic signed [CW-1:0]   gb_r [0:2];
  logic signed [CW-1:0]   gc_r [0:2];
  logic signed [DW-1:0]   gp_r, gq_r;
  logic signed [CW-1:0]   e1x, e1y, e2x, e2y;

  assign e1x = CW'(x1_r) - CW'(x0_r);
  assign e1y = CW'(y1_r) - CW'(y0_r);
  assign e2x = CW'(x2_r) - CW'(x0_r);
  assign e2y = CW'(y2_r) - CW'(y0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g2_vld_r <= 1'b0;
    end else begin
      g2_vld_r <= g1_vld_r;
    end
    gb_r[0] <= CW'(y1_r) - CW'(y2_r);
    gb_r[1] <= e2y;
    gb_r[2] <= CW'(y0_r) - CW'(y1_r);
    gc_r[0] <= CW'(x2_r) - CW'(x1_r);
    gc_r[1] <= CW'(x0_r) - CW'(x2_r);
    gc_r[2] <= e1x;
    gp_r    <= e1x * e2y;
    gq_r    <= e2x * e1y;
  end

  // geometry stage 3: twice the doubled area into the pending slot
  logic signed [DW:0]   dd;
  logic [DW:0]          dmag;
  logic                 pend_vld_r;
  logic signed [CW-1:0] pb_r [0:2];
  logic signed [CW-1:0] pc_r [0:2];
  logic [DW-1:0]        pden_r;
  logic                 pdeg_r;
  logic                 take;

  assign dd   = {gp_r[DW-1], gp_r} - {gq_r[DW-1], gq_r};
  assign dmag = dd[DW] ? (~dd + 1'b1) : dd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
    end else if (g2_vld_r) begin
      pend_vld_r <= 1'b1;
    end else if (take) begin
      pend_vld_r <= 1'b0;
    end
    if (g2_vld_r) begin
      pb_r   <= gb_r;
      pc_r   <= gc_r;
      pden_r <= {dmag[DW-2:0], 1'b0};
      pdeg_r <= (dd == '0);
    end
  end

  assign busy = g1_vld_r || g2_vld_r || pend_vld_r;

  // entry sequencer over the upper triangle
  logic                 act_r;
  logic [IW-1:0]        row_r, col_r;
  logic signed [CW-1:0] wb_r [0:2];
  logic signed [CW-1:0] wc_r [0:2];
  logic [DW-1:0]        wden_r;
  logic                 wdeg_r;
  logic                 seq_last;

  assign seq_last = act_r && (row_r == LAST_IDX);
  assign take     = pend_vld_r && (!act_r || seq_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      row_r <= '0;
      col_r <= '0;
    end else if (take) begin
      act_r <= 1'b1;
      row_r <= '0;
      col_r <= '0;
    end else if (act_r) begin
      if (seq_last) begin
        act_r <= 1'b0;
      end else if (col_r == LAST_IDX) begin
        row_r <= row_r + 1'b1;
        col_r <= row_r + 1'b1;
      end else begin
        col_r <= col_r + 1'b1;
      end
    end
    if (take) begin
      wb_r   <= pb_r;
      wc_r   <= pc_r;
      wden_r <= pden_r;
      wdeg_r <= pdeg_r;
    end
  end

  // operand selection for the two terms
  logic [1:0]           ia, im;
  logic                 ru, cu;
  logic signed [CW-1:0] s1x, s1y, s2x, s2y;
  logic [VW-1:0]        s1k;
  logic [CW-1:0]        a1x, a1y, a2x, a2y;
  ent_tag_t             s_tag;

  always_comb begin
    ru = (row_r < V_BASE);
    cu = (col_r < V_BASE);
    ia = ru ? row_r[1:0] : 2'(row_r - V_BASE);
    im = cu ? col_r[1:0] : 2'(col_r - V_BASE);
    if (ru && cu) begin
      s1k = cii_r; s1x = wb_r[ia]; s1y = wb_r[im];
      s2x = wc_r[ia]; s2y = wc_r[im];
    end else if (ru) begin
      s1k = cij_r; s1x = wb_r[ia]; s1y = wc_r[im];
      s2x = wc_r[ia]; s2y = wb_r[im];
    end else begin
      s1k = cii_r; s1x = wc_r[ia]; s1y = wc_r[im];
      s2x = wb_r[ia]; s2y = wb_r[im];
    end
    a1x = s1x[CW-1] ? (~s1x + 1'b1) : s1x;
    a1y = s1y[CW-1] ? (~s1y + 1'b1) : s1y;
    a2x = s2x[CW-1] ? (~s2x + 1'b1) : s2x;
    a2y = s2y[CW-1] ? (~s2y + 1'b1) : s2y;
    s_tag.row  = row_r;
    s_tag.col  = col_r;
    s_tag.deg  = wdeg_r;
    s_tag.last = seq_last;
    s_tag.den  = wden_r;
  end

  // e1: magnitudes and signs
  logic          e1_vld_r;
  ent_tag_t      e1_tag_r;
  logic [MW-1:0] m1x_r, m1y_r, m2x_r, m2y_r;
  logic          e1_n1_r, e1_n2_r;
  logic [VW-1:0] e1_k1_r, e1_k2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e1_vld_r <= 1'b0;
    end else begin
      e1_vld_r <= act_r;
    end
    e1_tag_r <= s_tag;
    m1x_r    <= a1x[MW-1:0];
    m1y_r    <= a1y[MW-1:0];
    m2x_r    <= a2x[MW-1:0];
    m2y_r    <= a2y[MW-1:0];
    e1_n1_r  <= s1x[CW-1] ^ s1y[CW-1];
    e1_n2_r  <= s2x[CW-1] ^ s2y[CW-1];
    e1_k1_r  <= s1k;
    e1_k2_r  <= mu_r;
  end

  // e2: component products
  logic          e2_vld_r;
  ent_tag_t      e2_tag_r;
  logic [PW-1:0] e2_p1_r, e2_p2_r;
  logic          e2_n1_r, e2_n2_r;
  logic [VW-1:0] e2_k1_r, e2_k2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e2_vld_r <= 1'b0;
    end else begin
      e2_vld_r <= e1_vld_r;
    end
    e2_tag_r <= e1_tag_r;
    e2_p1_r  <= m1x_r * m1y_r;
    e2_p2_r  <= m2x_r * m2y_r;
    e2_n1_r  <= e1_n1_r;
    e2_n2_r  <= e1_n2_r;
    e2_k1_r  <= e1_k1_r;
    e2_k2_r  <= e1_k2_r;
  end

  // e3: coefficient partial products
  logic          e3_vld_r;
  ent_tag_t      e3_tag_r;
  logic [PW-1:0] e3_lo1_r, e3_hi1_r, e3_lo2_r, e3_hi2_r;
  logic          e3_n1_r, e3_n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e3_vld_r <= 1'b0;
    end else begin
      e3_vld_r <= e2_vld_r;
    end
    e3_tag_r <= e2_tag_r;
    e3_lo1_r <= e2_p1_r[MW-1:0] * e2_k1_r;
    e3_hi1_r <= e2_p1_r[PW-1:MW] * e2_k1_r;
    e3_lo2_r <= e2_p2_r[MW-1:0] * e2_k2_r;
    e3_hi2_r <= e2_p2_r[PW-1:MW] * e2_k2_r;
    e3_n1_r  <= e2_n1_r;
    e3_n2_r  <= e2_n2_r;
  end

  // e4: full term magnitudes
  logic          e4_vld_r;
  ent_tag_t      e4_tag_r;
  logic [TW-1:0] e4_t1_r, e4_t2_r;
  logic          e4_n1_r, e4_n2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e4_vld_r <= 1'b0;
    end else begin
      e4_vld_r <= e3_vld_r;
    end
    e4_tag_r <= e3_tag_r;
    e4_t1_r  <= {{(TW-PW){1'b0}}, e3_lo1_r} + {e3_hi1_r, {MW{1'b0}}};
    e4_t2_r  <= {{(TW-PW){1'b0}}, e3_lo2_r} + {e3_hi2_r, {MW{1'b0}}};
    e4_n1_r  <= e3_n1_r;
    e4_n2_r  <= e3_n2_r;
  end

  // e5: signed terms
  logic          e5_vld_r;
  ent_tag_t      e5_tag_r;
  logic [NW-1:0] e5_s1_r, e5_s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e5_vld_r <= 1'b0;
    end else begin
      e5_vld_r <= e4_vld_r;
    end
    e5_tag_r <= e4_tag_r;
    e5_s1_r  <= e4_n1_r ? (~{1'b0, e4_t1_r} + 1'b1) : {1'b0, e4_t1_r};
    e5_s2_r  <= e4_n2_r ? (~{1'b0, e4_t2_r} + 1'b1) : {1'b0, e4_t2_r};
  end

  // e6: numerator sum
  logic          e6_vld_r;
  ent_tag_t      e6_tag_r;
  logic [SW-1:0] e6_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e6_vld_r <= 1'b0;
    end else begin
      e6_vld_r <= e5_vld_r;
    end
    e6_tag_r <= e5_tag_r;
    e6_sum_r <= {e5_s1_r[NW-1], e5_s1_r} + {e5_s2_r[NW-1], e5_s2_r};
  end

  // e7: numerator magnitude and sign
  logic          e7_vld_r;
  ent_tag_t      e7_tag_r;
  logic [NW-1:0] e7_mag_r;
  logic          e7_neg_r;
  logic [SW-1:0] sum_abs;

  assign sum_abs = e6_sum_r[SW-1] ? (~e6_sum_r + 1'b1) : e6_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e7_vld_r <= 1'b0;
    end else begin
      e7_vld_r <= e6_vld_r;
    end
    e7_tag_r <= e6_tag_r;
    e7_mag_r <= sum_abs[NW-1:0];
    e7_neg_r <= e6_sum_r[SW-1];
  end

  // division by twice the doubled area and saturation
  tes_div_pipe u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (e7_vld_r),
    .in_num   (e7_mag_r),
    .in_neg   (e7_neg_r),
    .in_tag   (e7_tag_r),
    .out_vld  (out_valid),
    .out_row  (out_row_index),
    .out_col  (out_col_index),
    .out_val  (out_entry_value),
    .out_deg  (out_degenerate),
    .out_last (out_last_entry)
  );

endmodule
